// ===== rtl/core/pointing_sentence_parser_macros.svh =====
// Assertion macros for the pointing sentence parser.
// Used by the RTL in rtl/core; clk and rst_n must be visible where they expand.
`ifndef POINTING_SENTENCE_PARSER_MACROS_SVH
`define POINTING_SENTENCE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define PSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PSP_ASSERT_IMP(label, ante, cons, msg)
`define PSP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/psp_pkg.sv =====
// Shared constants, types and header tables for the pointing sentence parser.
// No dependencies.
`default_nettype none

package psp_pkg;

    localparam int MAX_SENTENCE_DEF = 256;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam int MILLI_SCALE = 1000;

    // result kinds
    localparam logic [1:0] MSG_COMMAND = 2'd0;
    localparam logic [1:0] MSG_TRACKER = 2'd1;
    localparam logic [1:0] MSG_EXPIRED = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_T      = 8'h54;

    typedef struct packed {
        logic       clear;
        logic       feed;
        logic [7:0] data;
    } num_ctrl_t;

    typedef struct packed {
        logic [31:0] int_val;
        logic [31:0] milli_val;
    } num_val_t;

    // expected byte of "$GSL," at a given position
    function automatic logic [7:0] gsl_hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h53;
            3'd3:    c = 8'h4C;
            3'd4:    c = CH_COMMA;
            default: c = CH_DOLLAR;
        endcase
        return c;
    endfunction

    // expected byte of "$TRKUD," at a given position
    function automatic logic [7:0] trk_hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h52;
            3'd3:    c = 8'h4B;
            3'd4:    c = 8'h55;
            3'd5:    c = 8'h44;
            3'd6:    c = CH_COMMA;
            default: c = CH_DOLLAR;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/psp_number.sv =====
// Decimal field accumulator: sign, integer digits and up to three fraction digits.
// Gives the field as a wrapped integer and as a saturated value times 1000. Uses psp_pkg.
`default_nettype none

module psp_number (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire psp_pkg::num_ctrl_t  ctrl,
    output      psp_pkg::num_val_t   val
);
    import psp_pkg::*;

    localparam logic [2:0] NS_LEAD = 3'd0;
    localparam logic [2:0] NS_SIGN = 3'd1;
    localparam logic [2:0] NS_INT  = 3'd2;
    localparam logic [2:0] NS_FRAC = 3'd3;
    localparam logic [2:0] NS_STOP = 3'd4;

    // beyond this magnitude the milli value saturates for either sign
    localparam logic [22:0] MAG_CLAMP = 23'h400000;

    logic [2:0]  stage_reg, stage_next;
    logic        neg_reg, neg_next;
    logic [1:0]  fcount_reg, fcount_next;
    logic [31:0] int_reg, int_next;
    logic [22:0] mag_reg, mag_next;
    logic [9:0]  frac_reg, frac_next;

    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit;
    logic [31:0] int_acc;
    logic [25:0] mag_acc;
    logic [9:0]  frac_add;
    logic [32:0] milli_mag;
    logic [31:0] milli_val;

    assign is_digit = (ctrl.data >= CH_ZERO) && (ctrl.data <= CH_NINE);
    assign is_space = (ctrl.data == CH_SPACE) || ((ctrl.data >= 8'd9) && (ctrl.data <= 8'd13));
    assign digit    = 4'(ctrl.data - CH_ZERO);
    assign int_acc  = {int_reg[28:0], 3'b000} + {int_reg[30:0], 1'b0} + {28'd0, digit};
    assign mag_acc  = {mag_reg, 3'b000} + {2'b00, mag_reg, 1'b0} + {22'd0, digit};

    always_comb
    begin
        case (fcount_reg)
            2'd0:    frac_add = 10'(digit) * 10'd100;
            2'd1:    frac_add = 10'(digit) * 10'd10;
            default: frac_add = 10'(digit);
        endcase
    end

    always_comb
    begin
        stage_next  = stage_reg;
        neg_next    = neg_reg;
        fcount_next = fcount_reg;
        int_next    = int_reg;
        mag_next    = mag_reg;
        frac_next   = frac_reg;
        if (ctrl.clear)
        begin
            stage_next  = NS_LEAD;
            neg_next    = 1'b0;
            fcount_next = 2'd0;
            int_next    = 32'd0;
            mag_next    = 23'd0;
            frac_next   = 10'd0;
        end
        else if (ctrl.feed)
        begin
            case (stage_reg)
                NS_LEAD, NS_SIGN, NS_INT:
                begin
                    if ((stage_reg == NS_LEAD) && is_space)
                    begin
                        stage_next = NS_LEAD;
                    end
                    else if ((stage_reg == NS_LEAD) &&
                             ((ctrl.data == CH_PLUS) || (ctrl.data == CH_MINUS)))
                    begin
                        neg_next   = (ctrl.data == CH_MINUS);
                        stage_next = NS_SIGN;
                    end
                    else if (is_digit)
                    begin
                        stage_next = NS_INT;
                        int_next   = int_acc;
                        mag_next   = (mag_acc > 26'(MAG_CLAMP)) ? MAG_CLAMP : mag_acc[22:0];
                    end
                    else if (ctrl.data == CH_DOT)
                    begin
                        stage_next = NS_FRAC;
                    end
                    else
                    begin
                        stage_next = NS_STOP;
                    end
                end
                NS_FRAC:
                begin
                    if (!is_digit)
                    begin
                        stage_next = NS_STOP;
                    end
                    else if (fcount_reg != 2'd3)
                    begin
                        frac_next   = frac_reg + frac_add;
                        fcount_next = fcount_reg + 2'd1;
                    end
                end
                default:
                begin
                    stage_next = stage_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg  <= NS_LEAD;
            neg_reg    <= 1'b0;
            fcount_reg <= 2'd0;
            int_reg    <= 32'd0;
            mag_reg    <= 23'd0;
            frac_reg   <= 10'd0;
        end
        else
        begin
            stage_reg  <= stage_next;
            neg_reg    <= neg_next;
            fcount_reg <= fcount_next;
            int_reg    <= int_next;
            mag_reg    <= mag_next;
            frac_reg   <= frac_next;
        end
    end

    assign milli_mag = 33'(mag_reg) * 33'(MILLI_SCALE) + 33'(frac_reg);

    always_comb
    begin
        if (neg_reg)
        begin
            if (milli_mag >= 33'h080000000)
                milli_val = 32'h80000000;
            else
                milli_val = 32'd0 - milli_mag[31:0];
        end
        else
        begin
            if (milli_mag > 33'h07FFFFFFF)
                milli_val = 32'h7FFFFFFF;
            else
                milli_val = milli_mag[31:0];
        end
    end

    assign val = '{int_val: (neg_reg ? (32'd0 - int_reg) : int_reg), milli_val: milli_val};

endmodule

`default_nettype wire

// ===== rtl/core/pointing_sentence_parser.sv =====
// Pointing sentence parser: one byte or tick per cycle while no result stalls, input register then result register.
// A request waits in the input register; its result is then registered in the result register.
// Throughput: one request per cycle; a waiting result holds only the input register.
// Reset (async, low): sentence state, records and counters cleared, timeout = 3000 ticks.
// Depends on psp_pkg, psp_number and pointing_sentence_parser_macros.svh.
`default_nettype none

module pointing_sentence_parser #(
    parameter int MAX_SENTENCE = psp_pkg::MAX_SENTENCE_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output      logic               item_stall,
    input  wire logic               kind,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [15:0]        cfg_data,
    output      logic               result_valid,
    input  wire logic               result_stall,
    output      logic [1:0]         msg_type,
    output      logic [7:0]         cmd_counter,
    output      logic signed [31:0] azimuth_milli,
    output      logic signed [31:0] elevation_milli,
    output      logic [15:0]        range_value,
    output      logic [7:0]         target_id,
    output      logic signed [15:0] offset_x,
    output      logic signed [15:0] offset_y
);
    import psp_pkg::*;

`include "pointing_sentence_parser_macros.svh"

    localparam int LEN_W = $clog2(MAX_SENTENCE + 1);

    localparam logic [2:0] HS_START    = 3'd0;
    localparam logic [2:0] HS_GSL      = 3'd1;
    localparam logic [2:0] HS_TRK      = 3'd2;
    localparam logic [2:0] HS_GSL_BODY = 3'd3;
    localparam logic [2:0] HS_TRK_BODY = 3'd4;

    // input register
    logic       item_valid_reg;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic       advance;

    // parser state
    logic             in_sent_reg, in_sent_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [2:0]       hdr_reg, hdr_next;
    logic [2:0]       fnum_reg, fnum_next;
    logic             nonempty_reg, nonempty_next;
    logic [31:0]      pend_reg [4];
    logic [31:0]      pend_next [4];
    logic [3:0]       mask_reg, mask_next;
    logic [15:0]      timeout_reg;
    logic [15:0]      elapsed_reg, elapsed_next;
    logic             expiry_done_reg, expiry_done_next;

    // records
    logic [7:0]  cnt_reg, cnt_next;
    logic [31:0] az_reg, az_next;
    logic [31:0] el_reg, el_next;
    logic [15:0] rng_reg, rng_next;
    logic [7:0]  tid_reg, tid_next;
    logic [15:0] ox_reg, ox_next;
    logic [15:0] oy_reg, oy_next;

    // result register
    logic        res_valid_reg;
    logic [1:0]  res_type_reg;
    logic [7:0]  res_cnt_reg;
    logic [31:0] res_az_reg;
    logic [31:0] res_el_reg;
    logic [15:0] res_rng_reg;
    logic [7:0]  res_tid_reg;
    logic [15:0] res_ox_reg;
    logic [15:0] res_oy_reg;

    logic       emit;
    logic [1:0] emit_type;
    logic       commit;
    logic       finish;
    logic       num_clear;
    logic       num_feed;
    logic [3:0] mask_eff;
    logic [1:0] slot;
    logic       slot_ok;
    logic       milli_sel;

    num_ctrl_t num_ctrl;
    num_val_t  num_val;

    assign advance    = item_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign cfg_ready  = 1'b1;

    assign slot      = 2'(fnum_reg - 3'd1);
    assign slot_ok   = (fnum_reg >= 3'd1) && (fnum_reg <= 3'd4);
    assign milli_sel = (hdr_reg == HS_GSL_BODY) && ((slot == 2'd1) || (slot == 2'd2));

    always_comb
    begin
        in_sent_next     = in_sent_reg;
        len_next         = len_reg;
        hdr_next         = hdr_reg;
        fnum_next        = fnum_reg;
        nonempty_next    = nonempty_reg;
        pend_next        = pend_reg;
        mask_next        = mask_reg;
        elapsed_next     = elapsed_reg;
        expiry_done_next = expiry_done_reg;
        cnt_next         = cnt_reg;
        az_next          = az_reg;
        el_next          = el_reg;
        rng_next         = rng_reg;
        tid_next         = tid_reg;
        ox_next          = ox_reg;
        oy_next          = oy_reg;
        emit             = 1'b0;
        emit_type        = MSG_COMMAND;
        commit           = 1'b0;
        finish           = 1'b0;
        num_clear        = 1'b0;
        num_feed         = 1'b0;
        mask_eff         = mask_reg;

        if (advance)
        begin
            if (kind_reg)
            begin
                if (elapsed_reg != 16'hFFFF)
                    elapsed_next = elapsed_reg + 16'd1;
                if (!expiry_done_reg && (elapsed_next >= timeout_reg))
                begin
                    expiry_done_next = 1'b1;
                    az_next          = 32'd0;
                    el_next          = 32'd0;
                    rng_next         = 16'd0;
                    emit             = 1'b1;
                    emit_type        = MSG_EXPIRED;
                end
            end
            else if (byte_reg == CH_NUL)
            begin
                emit = 1'b0;
            end
            else if (byte_reg == CH_DOLLAR)
            begin
                in_sent_next  = 1'b1;
                len_next      = LEN_W'(1);
                hdr_next      = HS_START;
                fnum_next     = 3'd0;
                mask_next     = 4'd0;
                nonempty_next = 1'b0;
                num_clear     = 1'b1;
            end
            else if (in_sent_reg)
            begin
                if (len_reg >= LEN_W'(MAX_SENTENCE))
                begin
                    in_sent_next = 1'b0;
                end
                else
                begin
                    len_next = len_reg + LEN_W'(1);
                    if ((hdr_reg != HS_GSL_BODY) && (hdr_reg != HS_TRK_BODY))
                    begin
                        // header match, position is the old length
                        case (hdr_reg)
                            HS_START:
                            begin
                                if (byte_reg == CH_G)
                                    hdr_next = HS_GSL;
                                else if (byte_reg == CH_T)
                                    hdr_next = HS_TRK;
                                else
                                    in_sent_next = 1'b0;
                            end
                            HS_GSL:
                            begin
                                if ((len_reg >= LEN_W'(5)) ||
                                    (byte_reg != gsl_hdr_char(len_reg[2:0])))
                                begin
                                    in_sent_next = 1'b0;
                                end
                                else if (len_reg == LEN_W'(4))
                                begin
                                    hdr_next      = HS_GSL_BODY;
                                    fnum_next     = 3'd1;
                                    nonempty_next = 1'b0;
                                    num_clear     = 1'b1;
                                end
                            end
                            default:
                            begin
                                if ((len_reg >= LEN_W'(7)) ||
                                    (byte_reg != trk_hdr_char(len_reg[2:0])))
                                begin
                                    in_sent_next = 1'b0;
                                end
                                else if (len_reg == LEN_W'(6))
                                begin
                                    hdr_next      = HS_TRK_BODY;
                                    fnum_next     = 3'd1;
                                    nonempty_next = 1'b0;
                                    num_clear     = 1'b1;
                                end
                            end
                        endcase
                    end
                    else if (byte_reg == CH_COMMA)
                    begin
                        // empty fields collapse
                        commit = nonempty_reg;
                    end
                    else if (byte_reg != CH_STAR)
                    begin
                        nonempty_next = 1'b1;
                        num_feed      = 1'b1;
                    end
                    else
                    begin
                        commit       = 1'b1;
                        finish       = 1'b1;
                        in_sent_next = 1'b0;
                    end
                end
            end
        end

        if (commit)
        begin
            if (slot_ok)
            begin
                pend_next[slot] = milli_sel ? num_val.milli_val : num_val.int_val;
                mask_eff[slot]  = 1'b1;
            end
            mask_next     = mask_eff;
            if (fnum_reg != 3'd7)
                fnum_next = fnum_reg + 3'd1;
            nonempty_next = 1'b0;
            num_clear     = 1'b1;
        end

        if (finish)
        begin
            if (hdr_reg == HS_GSL_BODY)
            begin
                if (mask_eff[0]) cnt_next = pend_next[0][7:0];
                if (mask_eff[1]) az_next  = pend_next[1];
                if (mask_eff[2]) el_next  = pend_next[2];
                if (mask_eff[3]) rng_next = pend_next[3][15:0];
                elapsed_next     = 16'd0;
                expiry_done_next = 1'b0;
                emit_type        = MSG_COMMAND;
            end
            else
            begin
                if (mask_eff[0]) tid_next = pend_next[0][7:0];
                if (mask_eff[1]) ox_next  = pend_next[1][15:0];
                if (mask_eff[2]) oy_next  = pend_next[2][15:0];
                emit_type = MSG_TRACKER;
            end
            mask_next = 4'd0;
            emit      = 1'b1;
        end
    end

    assign num_ctrl.clear = num_clear;
    assign num_ctrl.feed  = num_feed;
    assign num_ctrl.data  = byte_reg;

    psp_number u_number (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (num_ctrl),
        .val   (num_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            kind_reg <= kind;
            byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sent_reg     <= 1'b0;
            len_reg         <= '0;
            hdr_reg         <= HS_START;
            fnum_reg        <= 3'd0;
            nonempty_reg    <= 1'b0;
            pend_reg        <= '{default: 32'd0};
            mask_reg        <= 4'd0;
            elapsed_reg     <= 16'd0;
            expiry_done_reg <= 1'b0;
            cnt_reg         <= 8'd0;
            az_reg          <= 32'd0;
            el_reg          <= 32'd0;
            rng_reg         <= 16'd0;
            tid_reg         <= 8'd0;
            ox_reg          <= 16'd0;
            oy_reg          <= 16'd0;
        end
        else
        begin
            in_sent_reg     <= in_sent_next;
            len_reg         <= len_next;
            hdr_reg         <= hdr_next;
            fnum_reg        <= fnum_next;
            nonempty_reg    <= nonempty_next;
            pend_reg        <= pend_next;
            mask_reg        <= mask_next;
            elapsed_reg     <= elapsed_next;
            expiry_done_reg <= expiry_done_next;
            cnt_reg         <= cnt_next;
            az_reg          <= az_next;
            el_reg          <= el_next;
            rng_reg         <= rng_next;
            tid_reg         <= tid_next;
            ox_reg          <= ox_next;
            oy_reg          <= oy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= emit;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            res_type_reg <= emit_type;
            res_cnt_reg  <= cnt_next;
            res_az_reg   <= az_next;
            res_el_reg   <= el_next;
            res_rng_reg  <= rng_next;
            res_tid_reg  <= tid_next;
            res_ox_reg   <= ox_next;
            res_oy_reg   <= oy_next;
        end
    end

    assign result_valid    = res_valid_reg;
    assign msg_type        = res_type_reg;
    assign cmd_counter     = res_cnt_reg;
    assign azimuth_milli   = res_az_reg;
    assign elevation_milli = res_el_reg;
    assign range_value     = res_rng_reg;
    assign target_id       = res_tid_reg;
    assign offset_x        = res_ox_reg;
    assign offset_y        = res_oy_reg;

    `PSP_ASSERT_IMP(a_expiry_clears, result_valid && (msg_type == MSG_EXPIRED), (azimuth_milli == 32'sd0) && (elevation_milli == 32'sd0) && (range_value == 16'd0), "expiry result carries a live pointing command")
    `PSP_ASSERT_NEXT(a_tick_counts, advance && kind_reg && (elapsed_reg != 16'hFFFF), elapsed_reg == ($past(elapsed_reg) + 16'd1), "tick did not advance the timeout count")
    `PSP_ASSERT_NEXT(a_cmd_restarts, advance && emit && (emit_type == MSG_COMMAND), (elapsed_reg == 16'd0) && !expiry_done_reg, "command sentence did not restart the timeout")
    `PSP_ASSERT_IMP(a_len_bound, in_sent_reg, len_reg <= LEN_W'(MAX_SENTENCE), "open sentence longer than the limit")

endmodule

`default_nettype wire

// ===== test/pointing_sentence_parser_tb.sv =====
// Self-checking testbench for pointing_sentence_parser: a queued driver feeds bytes and ticks,
// a predictor tracks the sentence parser state, and a monitor compares every result record.
// Depends on psp_pkg and the RTL under rtl/core.
`default_nettype none

module pointing_sentence_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import psp_pkg::*;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam logic [39:0] GSL_HEAD = "$GSL,";
    localparam logic [55:0] TRK_HEAD = "$TRKUD,";

    localparam int CYCLE_LIMIT = 3000000;
    localparam int PRINT_LIMIT = 40;

    typedef enum logic [2:0] {HDR_START, HDR_GSL, HDR_TRK, HDR_GSL_BODY, HDR_TRK_BODY} hdr_e;
    typedef enum logic [2:0] {NUM_LEAD, NUM_SIGN, NUM_INT, NUM_FRAC, NUM_STOP} num_e;

    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
    } request_t;

    typedef struct packed {
        logic [1:0]         msg;
        logic [7:0]         counter;
        logic signed [31:0] azimuth;
        logic signed [31:0] elevation;
        logic [15:0]        distance;
        logic [7:0]         target;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
    } pointing_record_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    logic               kind = KIND_BYTE;
    logic [7:0]         rx_byte = CH_NUL;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data = 16'd0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [1:0]         msg_type;
    logic [7:0]         cmd_counter;
    logic signed [31:0] azimuth_milli;
    logic signed [31:0] elevation_milli;
    logic [15:0]        range_value;
    logic [7:0]         target_id;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;

    pointing_sentence_parser u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .kind            (kind),
        .rx_byte         (rx_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .msg_type        (msg_type),
        .cmd_counter     (cmd_counter),
        .azimuth_milli   (azimuth_milli),
        .elevation_milli (elevation_milli),
        .range_value     (range_value),
        .target_id       (target_id),
        .offset_x        (offset_x),
        .offset_y        (offset_y)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    request_t         request_q[$];
    pointing_record_t expected_records[$];
    int               items_built = 0;
    int               errors = 0;
    int               cycle_count = 0;
    int               send_odds = 0;
    int               stall_odds = 0;
    int               gap_left = 0;
    int               stall_left = 0;
    request_t         next_req;
    pointing_record_t want;

    // parser shadow state
    logic [15:0]      timeout_copy = TIMEOUT_RESET;
    bit               p_open = 1'b0;
    int               p_len = 0;
    hdr_e             p_hdr = HDR_START;
    int               p_field = 0;
    bit               p_nonempty = 1'b0;
    num_e             n_stage = NUM_LEAD;
    bit               n_neg = 1'b0;
    int               n_fcount = 0;
    logic [31:0]      n_int = 32'd0;
    logic [63:0]      n_mag = 64'd0;
    logic [31:0]      n_frac = 32'd0;
    logic [31:0]      p_vals [4] = '{32'd0, 32'd0, 32'd0, 32'd0};
    logic [3:0]       p_mask = 4'd0;
    pointing_record_t cur = '0;
    logic [15:0]      elapsed = 16'd0;
    bit               expired = 1'b0;

    function automatic logic [7:0] head_byte(input bit trk, input int pos);
        if (trk)
            return TRK_HEAD[8*(6-pos) +: 8];
        return GSL_HEAD[8*(4-pos) +: 8];
    endfunction

    function automatic void clear_number();
        p_nonempty = 1'b0;
        n_stage = NUM_LEAD;
        n_neg = 1'b0;
        n_fcount = 0;
        n_int = 32'd0;
        n_mag = 64'd0;
        n_frac = 32'd0;
    endfunction

    function automatic void feed_number(input logic [7:0] b);
        bit          is_digit;
        logic [31:0] d;
        is_digit = (b >= CH_ZERO && b <= CH_NINE);
        d = {24'd0, b - CH_ZERO};
        if (n_stage == NUM_LEAD)
        begin
            if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
                return;
            if (b == CH_PLUS || b == CH_MINUS)
            begin
                n_neg = (b == CH_MINUS);
                n_stage = NUM_SIGN;
                return;
            end
        end
        case (n_stage)
            NUM_LEAD, NUM_SIGN, NUM_INT:
            begin
                if (is_digit)
                begin
                    n_stage = NUM_INT;
                    n_int = n_int * 32'd10 + d;
                    n_mag = n_mag * 64'd10 + {32'd0, d};
                    if (n_mag > 64'h1_0000_0000)
                        n_mag = 64'h1_0000_0000;
                end
                else if (b == CH_DOT)
                    n_stage = NUM_FRAC;
                else
                    n_stage = NUM_STOP;
            end
            NUM_FRAC:
            begin
                if (!is_digit)
                    n_stage = NUM_STOP;
                else if (n_fcount < 3)
                begin
                    // digits past the third are dropped, which truncates
                    case (n_fcount)
                        0:       n_frac = n_frac + d * 32'd100;
                        1:       n_frac = n_frac + d * 32'd10;
                        default: n_frac = n_frac + d;
                    endcase
                    n_fcount++;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] number_as_int();
        return n_neg ? 32'd0 - n_int : n_int;
    endfunction

    function automatic logic [31:0] number_as_milli();
        logic [63:0] m;
        m = n_mag * MILLI_SCALE + {32'd0, n_frac};
        if (n_neg)
        begin
            if (m >= 64'h8000_0000)
                return 32'h8000_0000;
            return 32'd0 - m[31:0];
        end
        if (m > 64'h7FFF_FFFF)
            return 32'h7FFF_FFFF;
        return m[31:0];
    endfunction

    function automatic void commit_field();
        int slot;
        if (p_field >= 1 && p_field <= 4)
        begin
            slot = p_field - 1;
            if (p_hdr == HDR_GSL_BODY && (slot == 1 || slot == 2))
                p_vals[slot] = number_as_milli();
            else
                p_vals[slot] = number_as_int();
            p_mask[slot] = 1'b1;
        end
        if (p_field < 7)
            p_field++;
        clear_number();
    endfunction

    function automatic void emit_record(input logic [1:0] m);
        pointing_record_t r;
        r = cur;
        r.msg = m;
        expected_records.push_back(r);
    endfunction

    // Advance the shadow parser by one accepted request.
    function automatic void parse_request(input logic is_tick, input logic [7:0] b);
        int pos;
        if (is_tick == KIND_TICK)
        begin
            if (elapsed != 16'hFFFF)
                elapsed++;
            if (!expired && elapsed >= timeout_copy)
            begin
                expired = 1'b1;
                cur.azimuth = 32'sd0;
                cur.elevation = 32'sd0;
                cur.distance = 16'd0;
                emit_record(MSG_EXPIRED);
            end
            return;
        end
        if (b == CH_NUL)
            return;
        if (b == CH_DOLLAR)
        begin
            p_open = 1'b1;
            p_len = 1;
            p_hdr = HDR_START;
            p_field = 0;
            p_mask = 4'd0;
            clear_number();
            return;
        end
        if (!p_open)
            return;
        if (p_len >= MAX_SENTENCE_DEF)
        begin
            p_open = 1'b0;
            return;
        end
        p_len++;
        pos = p_len - 1;

        if (p_hdr != HDR_GSL_BODY && p_hdr != HDR_TRK_BODY)
        begin
            if (p_hdr == HDR_START)
            begin
                if (b == head_byte(1'b0, 1))
                    p_hdr = HDR_GSL;
                else if (b == head_byte(1'b1, 1))
                    p_hdr = HDR_TRK;
                else
                    p_open = 1'b0;
            end
            else if (p_hdr == HDR_GSL)
            begin
                if (pos >= 5)
                    p_open = 1'b0;
                else if (b != head_byte(1'b0, pos))
                    p_open = 1'b0;
                else if (pos == 4)
                begin
                    p_hdr = HDR_GSL_BODY;
                    p_field = 1;
                    clear_number();
                end
            end
            else
            begin
                if (pos >= 7)
                    p_open = 1'b0;
                else if (b != head_byte(1'b1, pos))
                    p_open = 1'b0;
                else if (pos == 6)
                begin
                    p_hdr = HDR_TRK_BODY;
                    p_field = 1;
                    clear_number();
                end
            end
            return;
        end

        // empty fields collapse and do not advance the field count
        if (b == CH_COMMA)
        begin
            if (p_nonempty)
                commit_field();
            return;
        end
        if (b != CH_STAR)
        begin
            p_nonempty = 1'b1;
            feed_number(b);
            return;
        end

        // the star closes the last field, even an empty one
        commit_field();
        p_open = 1'b0;
        if (p_hdr == HDR_GSL_BODY)
        begin
            if (p_mask[0]) cur.counter = p_vals[0][7:0];
            if (p_mask[1]) cur.azimuth = p_vals[1];
            if (p_mask[2]) cur.elevation = p_vals[2];
            if (p_mask[3]) cur.distance = p_vals[3][15:0];
            elapsed = 16'd0;
            expired = 1'b0;
            emit_record(MSG_COMMAND);
        end
        else
        begin
            if (p_mask[0]) cur.target = p_vals[0][7:0];
            if (p_mask[1]) cur.dx = p_vals[1][15:0];
            if (p_mask[2]) cur.dy = p_vals[2][15:0];
            emit_record(MSG_TRACKER);
        end
        p_mask = 4'd0;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            kind <= KIND_BYTE;
            rx_byte <= CH_NUL;
            gap_left = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                parse_request(kind, rx_byte);
            if (!item_valid || !item_stall)
            begin
                if (gap_left == 0 && send_odds != 0 && $urandom_range(send_odds, 1) == 1)
                    gap_left = $urandom_range(16, 1);
                if (gap_left != 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    next_req = request_q.pop_front();
                    item_valid <= 1'b1;
                    kind <= next_req.is_tick;
                    rx_byte <= next_req.data;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t: %s expected %h, actual %h", $realtime, name, exp_v, act_v);
        end
    endtask

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_records.size() == 0)
                begin
                    errors++;
                    if (errors <= PRINT_LIMIT)
                        $display("%0t: msg_type expected none, actual %0d", $realtime, msg_type);
                end
                else
                begin
                    want = expected_records.pop_front();
                    check_field("msg_type", want.msg, msg_type);
                    check_field("cmd_counter", want.counter, cmd_counter);
                    check_field("azimuth_milli", want.azimuth, azimuth_milli);
                    check_field("elevation_milli", want.elevation, elevation_milli);
                    check_field("range_value", want.distance, range_value);
                    check_field("target_id", want.target, target_id);
                    check_field("offset_x", want.dx, offset_x);
                    check_field("offset_y", want.dy, offset_y);
                end
            end
            if (stall_left == 0 && stall_odds != 0 && $urandom_range(stall_odds, 1) == 1)
                stall_left = $urandom_range(16, 1);
            if (stall_left != 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        logic [31:0] r;
        r = $urandom_range(hi, lo);
        return r[7:0];
    endfunction

    task automatic push_byte(input logic [7:0] b);
        request_t r;
        r.is_tick = KIND_BYTE;
        r.data = b;
        request_q.push_back(r);
        items_built++;
    endtask

    task automatic push_tick(input int n);
        request_t r;
        r.is_tick = KIND_TICK;
        repeat (n)
        begin
            r.data = rand_byte(0, 255);
            request_q.push_back(r);
            items_built++;
        end
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // Random number text: blanks, sign, digits (sometimes far too many), fraction, junk.
    task automatic push_number_text();
        int sel;
        int n_dig;
        sel = $urandom_range(5, 0);
        if ($urandom_range(5, 0) == 0)
            repeat ($urandom_range(3, 1))
                push_byte($urandom_range(1, 0) ? CH_SPACE : rand_byte(9, 13));
        if (sel == 0)
            push_byte(CH_MINUS);
        else if (sel == 1)
            push_byte(CH_PLUS);
        sel = $urandom_range(19, 0);
        if (sel == 0)
            n_dig = 0;
        else if (sel <= 2)
            n_dig = $urandom_range(14, 9);
        else
            n_dig = $urandom_range(5, 1);
        repeat (n_dig)
            push_byte(CH_ZERO + rand_byte(0, 9));
        if ($urandom_range(2, 0) == 0)
        begin
            push_byte(CH_DOT);
            repeat ($urandom_range(5, 0))
                push_byte(CH_ZERO + rand_byte(0, 9));
        end
        if ($urandom_range(11, 0) == 0)
            push_byte(rand_byte(33, 126));
        if ($urandom_range(19, 0) == 0)
            push_byte(CH_NUL);
    endtask

    task automatic push_sentence();
        int  sel;
        int  n_fields;
        int  cut;
        int  i;
        bit  trk;
        sel = $urandom_range(99, 0);
        trk = 1'($urandom_range(1, 0));
        if (sel >= 94)
        begin
            repeat ($urandom_range(6, 1))
                push_byte(rand_byte(0, 255));
            return;
        end
        if (sel >= 80 && sel < 88)
        begin
            // header broken at a random position
            cut = trk ? $urandom_range(6, 1) : $urandom_range(4, 1);
            for (i = 0; i < cut; i++)
                push_byte(head_byte(trk, i));
            push_byte(rand_byte(33, 126));
        end
        else
        begin
            if (sel < 45)
                trk = 1'b0;
            else if (sel < 80)
                trk = 1'b1;
            for (i = 0; i < (trk ? 7 : 5); i++)
                push_byte(head_byte(trk, i));
        end
        n_fields = $urandom_range(6, 0);
        for (i = 0; i < n_fields; i++)
        begin
            if ($urandom_range(5, 0) == 0)
                push_byte(CH_COMMA);
            push_number_text();
            if (i != n_fields - 1)
                push_byte(CH_COMMA);
        end
        if ($urandom_range(7, 0) == 0)
            push_byte(CH_COMMA);
        // sentences cut short are dropped by the next dollar
        if (!(sel >= 88 && sel < 94))
            push_byte(CH_STAR);
        if ($urandom_range(3, 0) == 0)
            push_text("\r\n");
    endtask

    task automatic build_random(input int count);
        int goal;
        goal = items_built + count;
        while (items_built < goal)
        begin
            push_sentence();
            if ($urandom_range(9, 0) == 0)
                push_tick($urandom_range(60, 10));
            else
                push_tick($urandom_range(3, 0));
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_q.size() != 0 || item_valid || expected_records.size() != 0);
        // a request that causes no result may still be in the pipeline
        repeat (6) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        timeout_copy = v;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_odds = 5;
        stall_odds = 4;
        push_text("$GSL,255,359.999,-90.5,65535*\r\n");
        push_text("$GSL,-1,-2147483.648,2147483.6479,-1*");
        push_text("$GSL,1,99999999999,-99999999999.5,70000*");
        push_text("$TRKUD,7,-32768,32767*");
        push_text("$TRKUD,300,65535,-65537*");
        push_text("*stray,12*");
        push_text("$GSL,,,5,*");
        push_text("$GSL,  +12.3e5,\t-0.0009,.5,abc*");
        push_text("$TRKUD,9*");
        push_text("$GSL,4");
        push_byte(CH_NUL);
        push_text("2,1*");
        push_text("$TRKUD,5");
        push_byte(8'hFF);
        push_text("6,-7*");
        push_byte(8'hFF);
        push_text("$GSL,1,$TRKUD,3,4,5*");
        push_text("$GPS,1*$TRKX,1*$GSLX,2*$G*");
        push_text("$TRKUD,1,2,3,4,5,6,7,8,9*$GSL,1,2,3,4,5,6,7,8*");
        push_text("$GSL,-,+,.,-.*");
        // exactly the longest sentence allowed, then one byte longer
        push_text("$GSL,7,");
        repeat (247) push_byte(CH_SPACE);
        push_text("8*");
        push_text("$GSL,9,");
        repeat (248) push_byte(CH_SPACE);
        push_text("1*");
        wait_idle();

        write_timeout(16'd0);
        send_odds = 4;
        stall_odds = 4;
        build_random(150);
        wait_idle();

        write_timeout(16'($urandom_range(40, 2)));
        send_odds = 3;
        stall_odds = 8;
        build_random(150);
        wait_idle();

        // longest timeout, ticks never reach it here
        write_timeout(16'hFFFF);
        send_odds = 10;
        stall_odds = 2;
        build_random(150);
        wait_idle();

        write_timeout(16'd1);
        send_odds = 0;
        stall_odds = 0;
        build_random(150);
        wait_idle();

        if (expected_records.size() != 0)
        begin
            errors++;
            $display("%0t: results expected %0d more, actual 0",
                     $realtime, expected_records.size());
        end
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
